/* sv/assert_macros.svh */
// Assertion macros shared by the RTL of the matrix to quaternion block.
// Included by files that carry concurrent checks; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

/* sv/dcmq_pkg.sv */
// Package for the matrix to quaternion block: widths, stage layout, stage types
// and the single-step square root and division functions. No dependencies.
`timescale 1ns / 1ps
package dcmq_pkg;

    localparam int ELEM_W    = 16;
    localparam int SQ_STEPS  = 15;
    localparam int DIV_STEPS = 16;
    localparam int ST_SEL    = SQ_STEPS + 1;
    localparam int ST_OUT    = ST_SEL + DIV_STEPS + 1;
    localparam int NUM_ST    = ST_OUT + 1;

    typedef struct packed {
        logic [29:0] x;
        logic [16:0] rem;
        logic [14:0] root;
    } t_sq_lane;

    typedef struct packed {
        t_sq_lane [3:0]     lane;
        logic signed [16:0] da;
        logic signed [16:0] db;
        logic signed [16:0] dc;
        logic signed [16:0] sa;
        logic signed [16:0] sb;
        logic signed [16:0] sc;
    } t_sq_stage;

    typedef struct packed {
        logic        neg;
        logic        ovf;
        logic [15:0] lo;
        logic [15:0] rem;
        logic [15:0] quo;
    } t_dv_lane;

    typedef struct packed {
        t_dv_lane [2:0] lane;
        logic [14:0]    best;
        logic [1:0]     sel;
        logic           degen;
    } t_dv_stage;

    // One digit of the integer square root, two radicand bits per step.
    function automatic t_sq_lane sq_step(input t_sq_lane l);
        logic [18:0] t;
        logic [16:0] trial;
        t_sq_lane    r;
        t     = {l.rem, l.x[29:28]};
        trial = {l.root, 2'b01};
        r.x   = {l.x[27:0], 2'b00};
        if (t >= {2'b00, trial}) begin
            r.rem  = 17'(t - {2'b00, trial});
            r.root = {l.root[13:0], 1'b1};
        end else begin
            r.rem  = t[16:0];
            r.root = {l.root[13:0], 1'b0};
        end
        return r;
    endfunction

    // One quotient bit of a restoring division by the chosen magnitude.
    function automatic t_dv_lane dv_step(input t_dv_lane l, input logic [14:0] d);
        logic [16:0] t;
        t_dv_lane    r;
        t     = {l.rem, l.lo[15]};
        r     = l;
        r.lo  = {l.lo[14:0], 1'b0};
        if (t >= {2'b00, d}) begin
            r.rem = 16'(t - {2'b00, d});
            r.quo = {l.quo[14:0], 1'b1};
        end else begin
            r.rem = t[15:0];
            r.quo = {l.quo[14:0], 1'b0};
        end
        return r;
    endfunction

endpackage

/* sv/dcm_to_quaternion.sv */
// Top level of the matrix to quaternion block: the whole pipeline in one module.
// Depends on dcmq_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Converts a 3x3 direction cosine matrix in signed Q2.14 into a quaternion in
// signed Q2.14 by Shepperd's method. One matrix beat may enter every clock
// cycle while the first stage can take it, and each produces exactly one
// result beat, which is presented from the output register.
// The 34 register stages are the square root (one radicand stage and fifteen
// digit stages, four roots side by side), one selection stage, sixteen
// restoring divider stages (three lanes) and the output register. Every stage
// holds its own valid bit and moves on when the
// stage after it is empty or moving, so a stalled output only stops the beats
// behind it while empty stages further up keep taking new matrices. The
// largest candidate magnitude wins; on a tie the highest index is taken. If
// the chosen magnitude is zero all parts read zero and the degenerate flag is
// set. Quotients are truncated towards zero and saturated to Q2.14.
module dcm_to_quaternion
    import dcmq_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_axis_tvalid,
    output logic         o_s_axis_tready,
    // m00, m01, m02, m10, m11, m12, m20, m21, m22 from the lowest bit up.
    input  logic [143:0] i_s_axis_tdata,
    output logic         o_m_axis_tvalid,
    input  logic         i_m_axis_tready,
    // q_scalar, q_x, q_y, q_z from the lowest bit up.
    output logic [63:0]  o_m_axis_tdata,
    // largest_index [1:0], degenerate [2].
    output logic [2:0]   o_m_axis_tuser
);

    logic [NUM_ST-1:0] r_valid;
    logic [NUM_ST-1:0] adv;

    t_sq_stage r_sq [0:SQ_STEPS];
    t_dv_stage r_sel;
    t_dv_stage r_dv [0:DIV_STEPS-1];
    logic [63:0] r_out_tdata;
    logic [2:0]  r_out_tuser;

    t_sq_stage n_sq0;
    t_dv_stage n_sel;
    logic [63:0] n_out_tdata;
    logic [2:0]  n_out_tuser;

    // A stage may load when it is empty or its own beat is moving on.
    always_comb begin
        adv[ST_OUT] = !r_valid[ST_OUT] || i_m_axis_tready;
        for (int k = ST_OUT - 1; k >= 0; k--) begin
            adv[k] = !r_valid[k] || adv[k+1];
        end
    end

    assign o_s_axis_tready = adv[0];
    assign o_m_axis_tvalid = r_valid[ST_OUT];
    assign o_m_axis_tdata  = r_out_tdata;
    assign o_m_axis_tuser  = r_out_tuser;

    // Radicands and off-diagonal sums and differences.
    always_comb begin
        logic signed [18:0] e [0:8];
        logic signed [18:0] s [0:3];
        for (int i = 0; i < 9; i++) begin
            e[i] = 19'(signed'(i_s_axis_tdata[i*ELEM_W +: ELEM_W]));
        end
        s[0] = 19'sd16384 + e[0] + e[4] + e[8];
        s[1] = 19'sd16384 + e[0] - e[4] - e[8];
        s[2] = 19'sd16384 - e[0] + e[4] - e[8];
        s[3] = 19'sd16384 - e[0] - e[4] + e[8];
        for (int i = 0; i < 4; i++) begin
            n_sq0.lane[i].rem  = '0;
            n_sq0.lane[i].root = '0;
            if (s[i] <= 0) begin
                n_sq0.lane[i].x = '0;
            end else begin
                n_sq0.lane[i].x = {1'b0, s[i][16:0], 12'b0};
            end
        end
        n_sq0.da = 17'(e[5] - e[7]);
        n_sq0.db = 17'(e[6] - e[2]);
        n_sq0.dc = 17'(e[1] - e[3]);
        n_sq0.sa = 17'(e[1] + e[3]);
        n_sq0.sb = 17'(e[6] + e[2]);
        n_sq0.sc = 17'(e[5] + e[7]);
    end

    // Choose the largest root and line up the three numerators in ascending
    // component order, skipping the chosen component.
    always_comb begin
        logic [14:0]        m [0:3];
        logic [14:0]        best;
        logic [1:0]         sel;
        logic signed [16:0] num [0:2];
        logic [16:0]        absn;
        for (int i = 0; i < 4; i++) begin
            m[i] = r_sq[SQ_STEPS].lane[i].root;
        end
        best = m[0];
        for (int i = 1; i < 4; i++) begin
            if (m[i] > best) begin
                best = m[i];
            end
        end
        sel = 2'd0;
        for (int i = 1; i < 4; i++) begin
            if (m[i] == best) begin
                sel = 2'(i);
            end
        end
        case (sel)
            2'd0: begin
                num[0] = r_sq[SQ_STEPS].da;
                num[1] = r_sq[SQ_STEPS].db;
                num[2] = r_sq[SQ_STEPS].dc;
            end
            2'd1: begin
                num[0] = r_sq[SQ_STEPS].da;
                num[1] = r_sq[SQ_STEPS].sa;
                num[2] = r_sq[SQ_STEPS].sb;
            end
            2'd2: begin
                num[0] = r_sq[SQ_STEPS].db;
                num[1] = r_sq[SQ_STEPS].sa;
                num[2] = r_sq[SQ_STEPS].sc;
            end
            default: begin
                num[0] = r_sq[SQ_STEPS].dc;
                num[1] = r_sq[SQ_STEPS].sb;
                num[2] = r_sq[SQ_STEPS].sc;
            end
        endcase
        n_sel.best  = best;
        n_sel.degen = (best == '0);
        n_sel.sel   = (best == '0) ? 2'd0 : sel;
        for (int i = 0; i < 3; i++) begin
            absn = num[i][16] ? 17'(-num[i]) : 17'(num[i]);
            n_sel.lane[i].neg = num[i][16];
            n_sel.lane[i].lo  = {absn[3:0], 12'b0};
            n_sel.lane[i].rem = {3'b000, absn[16:4]};
            n_sel.lane[i].quo = '0;
            // The quotient reaches 2^16 when the upper dividend bits reach the divisor.
            n_sel.lane[i].ovf = ({2'b00, absn[16:4]} >= best);
        end
    end

    // Saturate, then place the chosen magnitude and the three quotients.
    always_comb begin
        logic [15:0] v [0:2];
        logic [15:0] q [0:3];
        logic [1:0]  k;
        t_dv_stage   f;
        f = r_dv[DIV_STEPS-1];
        for (int i = 0; i < 3; i++) begin
            if (f.lane[i].neg) begin
                v[i] = (f.lane[i].ovf || f.lane[i].quo > 16'd32768)
                       ? 16'h8000 : 16'(-f.lane[i].quo);
            end else begin
                v[i] = (f.lane[i].ovf || f.lane[i].quo[15])
                       ? 16'h7FFF : f.lane[i].quo;
            end
        end
        k = 2'd0;
        for (int i = 0; i < 4; i++) begin
            if (2'(i) == f.sel) begin
                q[i] = {1'b0, f.best};
            end else begin
                q[i] = v[k];
                k    = k + 2'd1;
            end
        end
        if (f.degen) begin
            n_out_tdata = '0;
        end else begin
            n_out_tdata = {q[3], q[2], q[1], q[0]};
        end
        n_out_tuser = {f.degen, f.sel};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            if (adv[0]) begin
                r_valid[0] <= i_s_axis_tvalid;
            end
            for (int k = 1; k < NUM_ST; k++) begin
                if (adv[k]) begin
                    r_valid[k] <= r_valid[k-1];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv[0]) begin
            r_sq[0] <= n_sq0;
        end
        for (int k = 1; k <= SQ_STEPS; k++) begin
            if (adv[k]) begin
                r_sq[k].da <= r_sq[k-1].da;
                r_sq[k].db <= r_sq[k-1].db;
                r_sq[k].dc <= r_sq[k-1].dc;
                r_sq[k].sa <= r_sq[k-1].sa;
                r_sq[k].sb <= r_sq[k-1].sb;
                r_sq[k].sc <= r_sq[k-1].sc;
                for (int i = 0; i < 4; i++) begin
                    r_sq[k].lane[i] <= sq_step(r_sq[k-1].lane[i]);
                end
            end
        end
        if (adv[ST_SEL]) begin
            r_sel <= n_sel;
        end
        for (int k = 0; k < DIV_STEPS; k++) begin
            if (adv[ST_SEL+1+k]) begin
                if (k == 0) begin
                    r_dv[k].best  <= r_sel.best;
                    r_dv[k].sel   <= r_sel.sel;
                    r_dv[k].degen <= r_sel.degen;
                    for (int i = 0; i < 3; i++) begin
                        r_dv[k].lane[i] <= dv_step(r_sel.lane[i], r_sel.best);
                    end
                end else begin
                    r_dv[k].best  <= r_dv[k-1].best;
                    r_dv[k].sel   <= r_dv[k-1].sel;
                    r_dv[k].degen <= r_dv[k-1].degen;
                    for (int i = 0; i < 3; i++) begin
                        r_dv[k].lane[i] <= dv_step(r_dv[k-1].lane[i], r_dv[k-1].best);
                    end
                end
            end
        end
        if (adv[ST_OUT]) begin
            r_out_tdata <= n_out_tdata;
            r_out_tuser <= n_out_tuser;
        end
    end

    // A degenerate result carries nothing but the flag.
    `ASSERT_IMPL(a_degen_zero, i_clk, i_rst_n, o_m_axis_tvalid && o_m_axis_tuser[2], o_m_axis_tdata == 64'd0 && o_m_axis_tuser[1:0] == 2'd0)
    // An accepted beat always lands in the first stage.
    `ASSERT_NEXT(a_accept_lands, i_clk, i_rst_n, i_s_axis_tvalid && o_s_axis_tready, r_valid[0])
    // The chosen component is a magnitude and is never negative.
    `ASSERT_IMPL(a_sel_positive, i_clk, i_rst_n, o_m_axis_tvalid && !o_m_axis_tuser[2], !o_m_axis_tdata[16*o_m_axis_tuser[1:0] + 15])

endmodule
